/* rtl/gcib_pkg.sv */
`timescale 1ns / 1ps
package gcib_pkg;

  // Angle word: signed degrees, 32 fraction bits
  localparam int ANG_W  = 42;
  // Sine/cosine word: signed Q30
  localparam int XY_W   = 34;
  // Vectoring word: signed Q30 with headroom for CORDIC gain
  localparam int VX_W   = 36;
  // Magnitude of a raw input angle during modulo reduction
  localparam int MAG_W  = 26;
  // Full product of two sine/cosine words
  localparam int PROD_W = 2 * XY_W;
  localparam int LANES  = 3;

  localparam logic signed [XY_W-1:0]  INV_GAIN = XY_W'(652032874);
  localparam logic signed [ANG_W-1:0] DEG_180  = ANG_W'(64'd180 << 32);
  localparam logic signed [ANG_W-1:0] DEG_360  = ANG_W'(64'd360 << 32);
  localparam logic [63:0] RAD_TO_DEG = 64'd246083499208;

  // Lane order inside the rotation and reduction cells
  localparam int LN_LAT1 = 0;
  localparam int LN_LAT2 = 1;
  localparam int LN_DLON = 2;

  typedef struct packed {
    logic                    s;
    logic [MAG_W-1:0]        m;
  } red_t;

  typedef struct packed {
    logic                    neg;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] a;
  } rot_t;

  typedef struct packed {
    logic                    zero;
    logic signed [VX_W-1:0]  x;
    logic signed [VX_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  // Divide by the odd number 2k+1
  function automatic logic [63:0] odd_div(input logic [63:0] v, input int k);
    case (k)
      0:  return v;
      1:  return v / 3;
      2:  return v / 5;
      3:  return v / 7;
      4:  return v / 9;
      5:  return v / 11;
      6:  return v / 13;
      7:  return v / 15;
      8:  return v / 17;
      9:  return v / 19;
      10: return v / 21;
      11: return v / 23;
      12: return v / 25;
      13: return v / 27;
      14: return v / 29;
      15: return v / 31;
      16: return v / 33;
      17: return v / 35;
      18: return v / 37;
      19: return v / 39;
      20: return v / 41;
      21: return v / 43;
      22: return v / 45;
      23: return v / 47;
      24: return v / 49;
      25: return v / 51;
      26: return v / 53;
      27: return v / 55;
      28: return v / 57;
      29: return v / 59;
      default: return 64'd0;
    endcase
  endfunction

  // atan(2^-i) in Q32 degrees, from a truncated Taylor series in Q60 radians
  function automatic logic [63:0] atan_q32(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] r;
    int          n;
    if (i == 0) begin
      return 64'd45 << 32;
    end
    sum = 64'd0;
    for (int k = 0; k < 30; k++) begin
      n = 2 * k + 1;
      if (i * n <= 60) begin
        term = odd_div(64'd1 << (60 - i * n), k);
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    r = (sum + (64'd1 << 27)) >> 28;
    return (r * (RAD_TO_DEG >> 16) + ((r * (RAD_TO_DEG & 64'hFFFF)) >> 16)) >> 16;
  endfunction

endpackage

/* rtl/gcib_mod_cell.sv */
`timescale 1ns / 1ps
module gcib_mod_cell #(
  parameter int FRAC  = 16,
  parameter int SHIFT = 0
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        v_in,
  input  gcib_pkg::red_t [gcib_pkg::LANES-1:0]        d_in,
  output logic                                        v_out,
  output gcib_pkg::red_t [gcib_pkg::LANES-1:0]        d_out
);

  localparam logic [39:0] MODK = (40'd360 << FRAC) << SHIFT;

  logic                                 v_r;
  gcib_pkg::red_t [gcib_pkg::LANES-1:0] d_r, d_nxt;

  // Subtract one scaled full turn from each magnitude when it fits
  always_comb begin
    d_nxt = d_in;
    for (int j = 0; j < gcib_pkg::LANES; j++) begin
      if ({14'd0, d_in[j].m} >= MODK) begin
        d_nxt[j].m = d_in[j].m - MODK[gcib_pkg::MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
    d_r <= d_nxt;
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule

/* rtl/gcib_rot_cell.sv */
`timescale 1ns / 1ps
module gcib_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        v_in,
  input  gcib_pkg::rot_t [gcib_pkg::LANES-1:0]        d_in,
  output logic                                        v_out,
  output gcib_pkg::rot_t [gcib_pkg::LANES-1:0]        d_out
);

  localparam logic signed [gcib_pkg::ANG_W-1:0] ATAN =
    gcib_pkg::ANG_W'(gcib_pkg::atan_q32(STAGE));

  logic                                 v_r;
  gcib_pkg::rot_t [gcib_pkg::LANES-1:0] d_r, d_nxt;

  // Rotate each lane toward zero residual angle
  always_comb begin
    d_nxt = d_in;
    for (int j = 0; j < gcib_pkg::LANES; j++) begin
      if (d_in[j].a >= 0) begin
        d_nxt[j].x = d_in[j].x - (d_in[j].y >>> STAGE);
        d_nxt[j].y = d_in[j].y + (d_in[j].x >>> STAGE);
        d_nxt[j].a = d_in[j].a - ATAN;
      end else begin
        d_nxt[j].x = d_in[j].x + (d_in[j].y >>> STAGE);
        d_nxt[j].y = d_in[j].y - (d_in[j].x >>> STAGE);
        d_nxt[j].a = d_in[j].a + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
    d_r <= d_nxt;
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule

/* rtl/gcib_vec_cell.sv */
`timescale 1ns / 1ps
module gcib_vec_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           v_in,
  input  gcib_pkg::vec_t d_in,
  output logic           v_out,
  output gcib_pkg::vec_t d_out
);

  localparam logic signed [gcib_pkg::ANG_W-1:0] ATAN =
    gcib_pkg::ANG_W'(gcib_pkg::atan_q32(STAGE));

  logic           v_r;
  gcib_pkg::vec_t d_r, d_nxt;

  // Drive y toward zero and accumulate the angle
  always_comb begin
    d_nxt = d_in;
    if (d_in.y >= 0) begin
      d_nxt.x = d_in.x + (d_in.y >>> STAGE);
      d_nxt.y = d_in.y - (d_in.x >>> STAGE);
      d_nxt.z = d_in.z + ATAN;
    end else begin
      d_nxt.x = d_in.x - (d_in.y >>> STAGE);
      d_nxt.y = d_in.y + (d_in.x >>> STAGE);
      d_nxt.z = d_in.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
    d_r <= d_nxt;
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule

/* rtl/great_circle_initial_bearing.sv */
`timescale 1ns / 1ps
// Initial great-circle bearing from a start to an end point. A fully pipelined
// row of CORDIC cells takes one point pair every clock cycle: busy stays low and
// start may be held high continuously. Each transaction gives exactly one result,
// shown on out_bearing for a single cycle with out_strobe high. Each pair passes the
// modulo 360 cells for all three angles (2 at the default format), the wrap and
// fold stage, the rotation row, the sign stage, the four multiply stages,
// the vectoring setup, the vectoring row and the output register. The receiver
// cannot stall the pipeline and must take every result as it appears.
module great_circle_initial_bearing #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES   = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_start_latitude,
  input  logic signed [24:0] in_start_longitude,
  input  logic signed [23:0] in_end_latitude,
  input  logic signed [24:0] in_end_longitude,
  output logic               out_strobe,
  output logic        [24:0] out_bearing
);

  localparam int F = ANGLE_FRAC_BITS;
  localparam int N = CORDIC_STAGES;
  localparam longint MOD_F   = longint'(64'd360 << F);
  localparam longint RED_Q   = (64'sd1 <<< 26) / MOD_F;
  localparam int     RED     = (RED_Q >= 1) ? $clog2(RED_Q + 1) : 1;

  localparam logic signed [39:0] HALF_F = 40'(64'd180 << F);
  localparam logic signed [39:0] FULL_F = 40'(64'd360 << F);
  localparam logic signed [39:0] QTR_F  = 40'(64'd90 << F);
  localparam logic signed [gcib_pkg::XY_W-1:0] NEAR_ZERO =
    gcib_pkg::XY_W'((64'd1 << (32 - N)) + 64'd32);
  localparam logic signed [gcib_pkg::PROD_W:0] HALF_Q30 =
    (gcib_pkg::PROD_W + 1)'(64'd1 << 29);
  localparam logic signed [gcib_pkg::ANG_W:0] ROUND_OUT =
    (gcib_pkg::ANG_W + 1)'(64'd1 << (31 - F));
  localparam logic signed [gcib_pkg::ANG_W:0] FULL_OUT =
    (gcib_pkg::ANG_W + 1)'(64'd360 << F);

  // Accept every cycle
  logic in_fire;
  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  // Form magnitudes for the modulo reduction
  logic signed [25:0]                   dlon_raw;
  logic        [25:0]                   dlon_abs;
  gcib_pkg::red_t [gcib_pkg::LANES-1:0] red_in;

  always_comb begin
    dlon_raw = 26'(in_end_longitude) - 26'(in_start_longitude);
    dlon_abs = dlon_raw[25] ? 26'(-dlon_raw) : 26'(dlon_raw);
    red_in[gcib_pkg::LN_LAT1].s = in_start_latitude[23];
    red_in[gcib_pkg::LN_LAT1].m = in_start_latitude[23] ?
      26'(-27'(in_start_latitude)) : 26'(in_start_latitude);
    red_in[gcib_pkg::LN_LAT2].s = in_end_latitude[23];
    red_in[gcib_pkg::LN_LAT2].m = in_end_latitude[23] ?
      26'(-27'(in_end_latitude)) : 26'(in_end_latitude);
    red_in[gcib_pkg::LN_DLON].s = dlon_raw[25];
    red_in[gcib_pkg::LN_DLON].m = dlon_abs;
  end

  // Modulo 360 reduction row
  logic                                 red_v [RED+1];
  gcib_pkg::red_t [gcib_pkg::LANES-1:0] red_d [RED+1];

  assign red_v[0] = in_fire;
  assign red_d[0] = red_in;

  for (genvar i = 0; i < RED; i++) begin : g_red
    gcib_mod_cell #(.FRAC(F), .SHIFT(RED - 1 - i)) u_mod (
      .clk  (clk),
      .rst_n(rst_n),
      .v_in (red_v[i]),
      .d_in (red_d[i]),
      .v_out(red_v[i+1]),
      .d_out(red_d[i+1])
    );
  end

  // Wrap to (-180,180], fold into [-90,90] and scale to Q32 degrees
  logic                                 prep_v_r;
  gcib_pkg::rot_t [gcib_pkg::LANES-1:0] prep_r, prep_nxt;

  always_comb begin
    for (int j = 0; j < gcib_pkg::LANES; j++) begin
      logic signed [39:0] w;
      logic               ng;
      w  = red_d[RED][j].s ? -$signed({14'd0, red_d[RED][j].m}) :
                              $signed({14'd0, red_d[RED][j].m});
      ng = 1'b0;
      if (w > HALF_F) begin
        w = w - FULL_F;
      end
      if (w <= -HALF_F) begin
        w = w + FULL_F;
      end
      if (w > QTR_F) begin
        w  = w - HALF_F;
        ng = 1'b1;
      end else if (w < -QTR_F) begin
        w  = w + HALF_F;
        ng = 1'b1;
      end
      prep_nxt[j].neg = ng;
      prep_nxt[j].x   = gcib_pkg::INV_GAIN;
      prep_nxt[j].y   = '0;
      prep_nxt[j].a   = gcib_pkg::ANG_W'(w) <<< (32 - F);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else begin
      prep_v_r <= red_v[RED];
    end
    prep_r <= prep_nxt;
  end

  // Rotation row: sine and cosine of the three angles
  logic                                 rot_v [N+1];
  gcib_pkg::rot_t [gcib_pkg::LANES-1:0] rot_d [N+1];

  assign rot_v[0] = prep_v_r;
  assign rot_d[0] = prep_r;

  for (genvar i = 0; i < N; i++) begin : g_rot
    gcib_rot_cell #(.STAGE(i)) u_rot (
      .clk  (clk),
      .rst_n(rst_n),
      .v_in (rot_v[i]),
      .d_in (rot_d[i]),
      .v_out(rot_v[i+1]),
      .d_out(rot_d[i+1])
    );
  end

  // Apply the half-turn sign
  logic                           trig_v_r;
  logic signed [gcib_pkg::XY_W-1:0] sn_r [gcib_pkg::LANES];
  logic signed [gcib_pkg::XY_W-1:0] cs_r [gcib_pkg::LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_v_r <= 1'b0;
    end else begin
      trig_v_r <= rot_v[N];
    end
    for (int j = 0; j < gcib_pkg::LANES; j++) begin
      sn_r[j] <= rot_d[N][j].neg ? -rot_d[N][j].y : rot_d[N][j].y;
      cs_r[j] <= rot_d[N][j].neg ? -rot_d[N][j].x : rot_d[N][j].x;
    end
  end

  // First products
  logic                               m1_v_r;
  logic signed [gcib_pkg::PROD_W-1:0] py_r, pt_r, pa_r;
  logic signed [gcib_pkg::XY_W-1:0]   cd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else begin
      m1_v_r <= trig_v_r;
    end
    py_r  <= sn_r[gcib_pkg::LN_DLON] * cs_r[gcib_pkg::LN_LAT2];
    pt_r  <= sn_r[gcib_pkg::LN_LAT1] * cs_r[gcib_pkg::LN_LAT2];
    pa_r  <= cs_r[gcib_pkg::LN_LAT1] * sn_r[gcib_pkg::LN_LAT2];
    cd1_r <= cs_r[gcib_pkg::LN_DLON];
  end

  // Round y and the partial term back to Q30
  logic                               m2_v_r;
  logic signed [gcib_pkg::XY_W-1:0]   y2_r, t2_r, cd2_r;
  logic signed [gcib_pkg::PROD_W-1:0] pa2_r;
  logic signed [gcib_pkg::PROD_W:0]   ry_sum, rt_sum;

  assign ry_sum = (gcib_pkg::PROD_W + 1)'(py_r) + HALF_Q30;
  assign rt_sum = (gcib_pkg::PROD_W + 1)'(pt_r) + HALF_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else begin
      m2_v_r <= m1_v_r;
    end
    y2_r  <= gcib_pkg::XY_W'(ry_sum >>> 30);
    t2_r  <= gcib_pkg::XY_W'(rt_sum >>> 30);
    cd2_r <= cd1_r;
    pa2_r <= pa_r;
  end

  // Second product
  logic                               m3_v_r;
  logic signed [gcib_pkg::PROD_W-1:0] pb3_r, pa3_r;
  logic signed [gcib_pkg::XY_W-1:0]   y3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else begin
      m3_v_r <= m2_v_r;
    end
    pb3_r <= t2_r * cd2_r;
    pa3_r <= pa2_r;
    y3_r  <= y2_r;
  end

  // Difference and round to Q30 for x
  logic                               m4_v_r;
  logic signed [gcib_pkg::XY_W-1:0]   x4_r, y4_r;
  logic signed [gcib_pkg::PROD_W:0]   rx_sum;

  assign rx_sum = (gcib_pkg::PROD_W + 1)'(pa3_r) - (gcib_pkg::PROD_W + 1)'(pb3_r)
                  + HALF_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_v_r <= 1'b0;
    end else begin
      m4_v_r <= m3_v_r;
    end
    x4_r <= gcib_pkg::XY_W'(rx_sum >>> 30);
    y4_r <= y3_r;
  end

  // Flag a degenerate direction and move x into the right half-plane
  logic           v0_v_r;
  gcib_pkg::vec_t v0_r, v0_nxt;

  always_comb begin
    logic signed [gcib_pkg::VX_W-1:0] xe, ye;
    xe = gcib_pkg::VX_W'(x4_r);
    ye = gcib_pkg::VX_W'(y4_r);
    v0_nxt.zero = !((x4_r > NEAR_ZERO) || (x4_r < -NEAR_ZERO) ||
                    (y4_r > NEAR_ZERO) || (y4_r < -NEAR_ZERO));
    if (x4_r < 0) begin
      v0_nxt.x = -xe;
      v0_nxt.y = -ye;
      v0_nxt.z = gcib_pkg::DEG_180;
    end else begin
      v0_nxt.x = xe;
      v0_nxt.y = ye;
      v0_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_v_r <= 1'b0;
    end else begin
      v0_v_r <= m4_v_r;
    end
    v0_r <= v0_nxt;
  end

  // Vectoring row: atan2
  logic           vec_v [N+1];
  gcib_pkg::vec_t vec_d [N+1];

  assign vec_v[0] = v0_v_r;
  assign vec_d[0] = v0_r;

  for (genvar i = 0; i < N; i++) begin : g_vec
    gcib_vec_cell #(.STAGE(i)) u_vec (
      .clk  (clk),
      .rst_n(rst_n),
      .v_in (vec_v[i]),
      .d_in (vec_d[i]),
      .v_out(vec_v[i+1]),
      .d_out(vec_d[i+1])
    );
  end

  // Fold into [0,360), round to the output format, force zero for a degenerate direction, hold for one cycle
  logic                          out_strobe_r;
  logic [24:0]                   out_bearing_r, bearing_nxt;

  always_comb begin
    logic signed [gcib_pkg::ANG_W:0] zf;
    logic signed [gcib_pkg::ANG_W:0] q;
    zf = (gcib_pkg::ANG_W + 1)'(vec_d[N].z);
    if (zf < 0) begin
      zf = zf + (gcib_pkg::ANG_W + 1)'(gcib_pkg::DEG_360);
    end else if (zf >= (gcib_pkg::ANG_W + 1)'(gcib_pkg::DEG_360)) begin
      zf = zf - (gcib_pkg::ANG_W + 1)'(gcib_pkg::DEG_360);
    end
    q = (zf + ROUND_OUT) >>> (32 - F);
    if (q >= FULL_OUT) begin
      q = q - FULL_OUT;
    end
    bearing_nxt = vec_d[N].zero ? 25'd0 : q[24:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vec_v[N];
    end
    out_bearing_r <= bearing_nxt;
  end

  assign out_strobe  = out_strobe_r;
  assign out_bearing = out_bearing_r;

endmodule

/* tb/gcib_checker.sv */
`timescale 1ns / 1ps
module gcib_checker #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES   = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [23:0] in_start_latitude,
  input  logic signed [24:0] in_start_longitude,
  input  logic signed [23:0] in_end_latitude,
  input  logic signed [24:0] in_end_longitude,
  input  logic               out_strobe,
  input  logic        [24:0] out_bearing,
  output int                 fail_count,
  output int                 pending_count,
  output int                 checked_count
);

  localparam longint ONE_DEG   = 64'sd1 << 32;
  localparam longint DEG_90    = 90 * ONE_DEG;
  localparam longint DEG_180   = 180 * ONE_DEG;
  localparam longint DEG_360   = 360 * ONE_DEG;
  localparam longint INV_GAIN  = 64'sd652032874;
  localparam longint HALF_Q30  = 64'sd1 << 29;
  localparam longint NEAR_ZERO = (64'sd1 << (32 - CORDIC_STAGES)) + 32;
  localparam longint unsigned RAD_TO_DEG = 64'd246083499208;

  longint     atan_deg[32];
  logic [24:0] bearing_q[$];

  // Build the arctangent table in Q32 degrees
  initial begin
    longint          sum;
    longint          term;
    longint unsigned r;
    atan_deg[0] = 45 * ONE_DEG;
    for (int i = 1; i < 32; i++) begin
      sum = 0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        term = longint'((64'd1 << (60 - i * (2 * k + 1))) / longint'(2 * k + 1));
        sum = (k % 2) ? sum - term : sum + term;
      end
      r = (longint'(sum) + (64'd1 << 27)) >> 28;
      atan_deg[i] = longint'((r * (RAD_TO_DEG >> 16)
                    + ((r * (RAD_TO_DEG & 64'hFFFF)) >> 16)) >> 16);
    end
  end

  function automatic longint round_q30(longint v);
    return (v + HALF_Q30) >>> 30;
  endfunction

  // Rotation CORDIC: sine and cosine in Q30 of a Q32-degree angle
  function automatic void rotate_angle(input longint ang, output longint s,
                                       output longint c);
    longint x, y, nx;
    bit     flip;
    x = INV_GAIN;
    y = 0;
    flip = 0;
    ang = ang % DEG_360;
    if (ang > DEG_180) ang -= DEG_360;
    if (ang <= -DEG_180) ang += DEG_360;
    if (ang > DEG_90) begin
      ang -= DEG_180;
      flip = 1;
    end else if (ang < -DEG_90) begin
      ang += DEG_180;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (ang >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        ang -= atan_deg[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        ang += atan_deg[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Vectoring CORDIC: angle of (x, y) in Q32 degrees
  function automatic longint vector_angle(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = DEG_180;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_deg[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_deg[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic logic [24:0] predict_bearing(
    logic signed [23:0] lat1_in, logic signed [24:0] lon1_in,
    logic signed [23:0] lat2_in, logic signed [24:0] lon2_in);
    longint sc, s1, c1, s2, c2, sd, cd, y, x, z, q;
    sc = 64'sd1 << (32 - ANGLE_FRAC_BITS);
    rotate_angle(longint'(lat1_in) * sc, s1, c1);
    rotate_angle(longint'(lat2_in) * sc, s2, c2);
    rotate_angle((longint'(lon2_in) - longint'(lon1_in)) * sc, sd, cd);
    y = round_q30(sd * c2);
    x = round_q30(c1 * s2 - round_q30(s1 * c2) * cd);
    q = 0;
    // Hold the bearing at zero for a degenerate direction
    if (x > NEAR_ZERO || x < -NEAR_ZERO || y > NEAR_ZERO || y < -NEAR_ZERO) begin
      z = vector_angle(y, x);
      while (z < 0) z += DEG_360;
      while (z >= DEG_360) z -= DEG_360;
      q = (z + (64'sd1 << (31 - ANGLE_FRAC_BITS))) >>> (32 - ANGLE_FRAC_BITS);
      if (q >= (64'sd360 << ANGLE_FRAC_BITS)) q -= 64'sd360 << ANGLE_FRAC_BITS;
    end
    return q[24:0];
  endfunction

  assign pending_count = bearing_q.size();

  // Predict on each accepted transaction, compare each strobed result
  always @(posedge clk) begin
    logic [24:0] want;
    if (!rst_n) begin
      fail_count <= 0;
      checked_count <= 0;
    end else begin
      if (start && !busy) begin
        bearing_q.push_back(predict_bearing(in_start_latitude, in_start_longitude,
                                            in_end_latitude, in_end_longitude));
      end
      if (out_strobe) begin
        if (bearing_q.size() == 0) begin
          $display("%0t: unexpected bearing result %0d", $time, out_bearing);
          fail_count <= fail_count + 1;
        end else begin
          want = bearing_q.pop_front();
          checked_count <= checked_count + 1;
          if (want !== out_bearing) begin
            $display("%0t: bearing mismatch, expected %0d, actual %0d",
                     $time, want, out_bearing);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int LAT_MAX    = 5898240;
  localparam int LON_MAX    = 11796480;
  localparam int LIMIT      = 300000;
  localparam int RANDOM_TXN = 320;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [23:0] in_start_latitude;
  logic signed [24:0] in_start_longitude;
  logic signed [23:0] in_end_latitude;
  logic signed [24:0] in_end_longitude;
  logic               out_strobe;
  logic        [24:0] out_bearing;
  int                 fail_count;
  int                 pending_count;
  int                 checked_count;
  int                 cycle_count = 0;

  great_circle_initial_bearing i_dut (.*);

  gcib_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one transaction and hold it until accepted, then sometimes idle a while
  task automatic send_points(int lat1, int lon1, int lat2, int lon2);
    int gap;
    start <= 1'b1;
    in_start_latitude <= lat1[23:0];
    in_start_longitude <= lon1[24:0];
    in_end_latitude <= lat2[23:0];
    in_end_longitude <= lon2[24:0];
    do @(posedge clk); while (busy);
    gap = $urandom_range(0, 99);
    if (gap < 45) gap = 0;
    else if (gap < 92) gap = $urandom_range(1, 4);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int rand_lat(bit full);
    return full ? int'($signed(24'($urandom))) : $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
  endfunction

  function automatic int rand_lon(bit full);
    return full ? int'($signed(25'($urandom))) : $urandom_range(0, 2 * LON_MAX) - LON_MAX;
  endfunction

  initial begin
    int lat1, lon1, mode, burst;
    rst_n = 0;
    start = 0;
    in_start_latitude = '0;
    in_start_longitude = '0;
    in_end_latitude = '0;
    in_end_longitude = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: coincident, poles, antipodal, cardinal headings, range extremes
    send_points(0, 0, 0, 0);
    send_points(1234567, -7654321, 1234567, -7654321);
    send_points(LAT_MAX, 0, LAT_MAX, LON_MAX);
    send_points(-LAT_MAX, 100, -LAT_MAX, -5000000);
    send_points(0, 0, 0, LON_MAX);
    send_points(2000000, 3000000, -2000000, 3000000 - LON_MAX);
    send_points(0, 0, 65536, 0);
    send_points(0, 0, -65536, 0);
    send_points(0, 0, 0, 65536);
    send_points(0, 0, 0, -65536);
    send_points(0, -LON_MAX, 0, LON_MAX);
    send_points(0, LON_MAX, 0, -LON_MAX);
    send_points(0, -LON_MAX + 65536, 0, LON_MAX - 65536);
    send_points(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    send_points(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
    send_points(-8388608, -16777216, 8388607, 16777215);
    send_points(8388607, 16777215, -8388608, -16777216);
    send_points(0, 0, 1, 0);
    send_points(0, 0, 0, 1);
    send_points(3276800, 100000, 3276801, 100000);

    // Random: mostly in range, some full width, some near-coincident and antipodal pairs
    for (int n = 0; n < RANDOM_TXN; n++) begin
      mode = $urandom_range(0, 9);
      lat1 = rand_lat(mode == 0);
      lon1 = rand_lon(mode == 0);
      if (mode == 1)
        send_points(lat1, lon1, lat1 + $urandom_range(0, 8) - 4,
                    lon1 + $urandom_range(0, 8) - 4);
      else if (mode == 2)
        send_points(lat1, lon1, -lat1, lon1 + (lon1 > 0 ? -LON_MAX : LON_MAX));
      else
        send_points(lat1, lon1, rand_lat(mode == 0), rand_lon(mode == 0));
      // Throw in a back-to-back burst now and then
      if ($urandom_range(0, 30) == 0) begin
        burst = $urandom_range(5, 20);
        for (int b = 0; b < burst; b++) begin
          start <= 1'b1;
          in_start_latitude <= 24'(rand_lat(0));
          in_start_longitude <= 25'(rand_lon(0));
          in_end_latitude <= 24'(rand_lat(0));
          in_end_longitude <= 25'(rand_lon(0));
          do @(posedge clk); while (busy);
        end
      end
    end
    start <= 1'b0;

    // Drain the pipeline
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Checked %0d bearings from directed corners, full-width and random pairs,",
             checked_count);
    $display("with random idle gaps and back-to-back bursts; %0d mismatches.", fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
